FILE: src/chtk_pkg.sv
// ----------------------------------------------------------------------------
// chtk_pkg: shared types and constants of the chained hash table
// Request and result structs, sizes, hash mix function and state encodings.
// ----------------------------------------------------------------------------
package chtk_pkg;

    localparam int unsigned Buckets    = 1024;
    localparam int unsigned PoolNodes  = 1024;
    localparam int unsigned BucketW    = $clog2(Buckets);
    localparam int unsigned NodeW      = $clog2(PoolNodes);
    localparam int unsigned LinkW      = $clog2(PoolNodes + 1);
    localparam int unsigned CountW     = 12;
    localparam int unsigned CfgW       = 11;
    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
    localparam logic [31:0] KnuthMult  = 32'd2654435761;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic        operation;
        logic [31:0] key;
        logic [31:0] value_in;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [31:0]       value_out;
        logic [CountW-1:0] entry_total;
    } t_rsp;

    // Classified request handed from the front to the back.
    typedef struct packed {
        logic               operation;
        logic [31:0]        key;
        logic [31:0]        value_in;
        logic [BucketW-1:0] bucket;
    } t_job;

    typedef enum logic [2:0] {
        FS_IDLE, FS_MULT, FS_DIV, FS_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        BS_IDLE, BS_HEAD, BS_HEADCHK, BS_NODE, BS_NODECHK, BS_DONE, BS_CLEAR
    } t_bstate;

    function automatic logic [31:0] jenkins_mix(input logic [31:0] k_in);
        logic [31:0] k;
        k = k_in;
        k = k + (k << 12);
        k = k ^ (k >> 22);
        k = k + (k << 4);
        k = k ^ (k >> 9);
        k = k + (k << 10);
        k = k ^ (k >> 2);
        k = k + (k << 7);
        k = k ^ (k >> 12);
        return k;
    endfunction

endpackage

FILE: src/chained_hash_table_int_key_unit.sv
// ----------------------------------------------------------------------------
// chained_hash_table_int_key_unit: integer-key chained hash table
// Front end hashes requests into a two-entry queue; back end runs the table.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// for one cycle with o_valid high and cannot be stalled. The front end hashes
// each request, multiplies it and reduces it modulo the bucket count, clamped
// to 1..1024, with a one-bit-per-cycle division; it takes the next request once
// it has pushed the job into the queue, so the back end, which does inserts and
// walks the chain node by node on a lookup, can work on an earlier request.
// After reset the back end clears all 1024 entries of the bucket valid
// memory; up to three requests are taken meanwhile and wait for it.
// Configuration writes are accepted whenever no request is in flight, the
// back end is not clearing its memory after reset and start is low.
module chained_hash_table_int_key_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  chtk_pkg::t_req            i_req,
    output logic                      o_valid,
    output chtk_pkg::t_rsp            o_rsp,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [chtk_pkg::CfgW-1:0] i_cfg_data
);
    import chtk_pkg::*;

    logic [CfgW-1:0] r_bucket_count;
    logic f_busy, q_full, q_empty, push, pop, b_idle;
    t_job f_job, q_job;

    assign busy        = f_busy;
    assign o_cfg_ready = !f_busy && q_empty && b_idle && !start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= CfgW'(Buckets);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_bucket_count <= i_cfg_data;
        end
    end

    chtk_front u_front (
        .i_clk, .i_rst_n, .i_start(start), .i_req,
        .i_bucket_count(r_bucket_count), .i_q_full(q_full),
        .o_busy(f_busy), .o_push(push), .o_job(f_job)
    );

    chtk_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_job(f_job), .i_pop(pop),
        .o_full(q_full), .o_empty(q_empty), .o_job(q_job)
    );

    chtk_back u_back (
        .i_clk, .i_rst_n, .i_empty(q_empty), .i_job(q_job), .o_pop(pop),
        .o_idle(b_idle), .o_strobe(o_valid), .o_rsp
    );

endmodule

FILE: src/chtk_front.sv
// ----------------------------------------------------------------------------
// chtk_front: request intake and bucket hashing
// Mixes the key, scales it, and reduces it modulo the bucket count by
// restoring division, one quotient bit per cycle. Pushes jobs into a queue.
// ----------------------------------------------------------------------------
module chtk_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  chtk_pkg::t_req          i_req,
    input  logic [chtk_pkg::CfgW-1:0] i_bucket_count,
    input  logic                    i_q_full,
    output logic                    o_busy,
    output logic                    o_push,
    output chtk_pkg::t_job          o_job
);
    import chtk_pkg::*;

    t_fstate r_state, n_state;
    t_req    r_req;
    logic [31:0] r_mix;
    logic [31:0] r_quot;
    logic [CfgW-1:0] r_rem;
    logic [CfgW-1:0] r_div;
    logic [4:0] r_bit;
    logic [CfgW:0] w_trial;
    logic [CfgW-1:0] w_div;

    always_comb begin
        if (i_bucket_count == '0) begin
            w_div = CfgW'(1);
        end else if (i_bucket_count > CfgW'(Buckets)) begin
            w_div = CfgW'(Buckets);
        end else begin
            w_div = i_bucket_count;
        end
    end

    assign w_trial = {r_rem, r_quot[31]};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: if (i_start) n_state = FS_MULT;
            FS_MULT: n_state = FS_DIV;
            FS_DIV:  if (r_bit == 5'd0) n_state = FS_PUSH;
            FS_PUSH: if (!i_q_full) n_state = FS_IDLE;
            default: n_state = FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            FS_IDLE: begin
                if (i_start) begin
                    r_req <= i_req;
                    r_mix <= jenkins_mix(i_req.key);
                    r_div <= w_div;
                end
            end
            FS_MULT: begin
                r_quot <= 32'((r_mix >> 3) * KnuthMult);
                r_rem  <= '0;
                r_bit  <= 5'd31;
            end
            FS_DIV: begin
                // Remainder stays below the divisor, so one compare suffices.
                if (w_trial >= {1'b0, r_div}) begin
                    r_rem <= CfgW'(w_trial - {1'b0, r_div});
                end else begin
                    r_rem <= w_trial[CfgW-1:0];
                end
                r_quot <= {r_quot[30:0], 1'b0};
                r_bit  <= r_bit - 5'd1;
            end
            FS_PUSH: ;
            default: ;
        endcase
    end

    always_comb begin
        o_busy          = (r_state != FS_IDLE);
        o_push          = (r_state == FS_PUSH) && !i_q_full;
        o_job.operation = r_req.operation;
        o_job.key       = r_req.key;
        o_job.value_in  = r_req.value_in;
        o_job.bucket    = r_rem[BucketW-1:0];
    end

endmodule

FILE: src/chtk_queue.sv
// ----------------------------------------------------------------------------
// chtk_queue: two-entry job queue between front and back
// A small circular buffer with separate full and empty flags.
// ----------------------------------------------------------------------------
module chtk_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  chtk_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output chtk_pkg::t_job o_job
);
    import chtk_pkg::*;

    t_job r_slot [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_job;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_slot[r_rp];

endmodule

FILE: src/chtk_back.sv
// ----------------------------------------------------------------------------
// chtk_back: table storage and chain walker
// Holds head and node memories, performs inserts and walks chains on lookup.
// The bucket valid memory is cleared one entry per cycle after reset.
// ----------------------------------------------------------------------------
module chtk_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  chtk_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_idle,
    output logic           o_strobe,
    output chtk_pkg::t_rsp o_rsp
);
    import chtk_pkg::*;

    logic             m_hvalid[Buckets];
    logic [31:0]      m_hkey [Buckets];
    logic [31:0]      m_hval [Buckets];
    logic [LinkW-1:0] m_hlink[Buckets];
    logic [31:0]      m_nkey [PoolNodes];
    logic [31:0]      m_nval [PoolNodes];
    logic [LinkW-1:0] m_nlink[PoolNodes];

    t_bstate r_state, n_state;
    t_job    r_job;
    logic [31:0]      r_rkey, r_rval;
    logic [LinkW-1:0] r_rlink;
    logic             r_rhv;
    logic [BucketW-1:0] r_clr;
    logic [LinkW-1:0] r_link;
    logic [LinkW-1:0] r_pool;
    logic [LinkW-1:0] r_steps;
    logic [CountW-1:0] r_count;
    logic [1:0]  r_status;
    logic [31:0] r_vout;
    logic        r_strobe;
    logic        w_hv;
    logic        w_link_ok;
    logic [NodeW-1:0] w_nidx;

    assign w_hv      = r_rhv;
    assign w_link_ok = (r_rlink != '0) && (r_rlink <= LinkW'(PoolNodes))
                       && (r_steps < LinkW'(PoolNodes));
    assign w_nidx    = NodeW'(r_link - LinkW'(1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_CLEAR:   if (r_clr == BucketW'(Buckets - 1)) n_state = BS_IDLE;
            BS_IDLE:    if (!i_empty) n_state = BS_HEAD;
            BS_HEAD:    n_state = BS_HEADCHK;
            BS_HEADCHK: begin
                if (r_job.operation == OP_INSERT || !w_hv || r_rkey == r_job.key
                        || !w_link_ok) begin
                    n_state = BS_DONE;
                end else begin
                    n_state = BS_NODE;
                end
            end
            BS_NODE:    n_state = BS_NODECHK;
            BS_NODECHK: begin
                if (r_rkey == r_job.key || !w_link_ok) n_state = BS_DONE;
                else n_state = BS_NODE;
            end
            BS_DONE:    n_state = BS_IDLE;
            default:    n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_CLEAR;
            r_clr    <= '0;
            r_pool   <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == BS_DONE);
            if (r_state == BS_CLEAR) r_clr <= r_clr + BucketW'(1);
            if (r_state == BS_HEADCHK && r_job.operation == OP_INSERT) begin
                if (!w_hv) begin
                    if (r_count != CountMax) r_count <= r_count + CountW'(1);
                end else if (r_pool < LinkW'(PoolNodes)) begin
                    r_pool <= r_pool + LinkW'(1);
                    if (r_count != CountMax) r_count <= r_count + CountW'(1);
                end
            end
        end
    end

    // Memory reads, registered.
    always_ff @(posedge i_clk) begin
        if (r_state == BS_HEAD) begin
            r_rhv   <= m_hvalid[r_job.bucket];
            r_rkey  <= m_hkey[r_job.bucket];
            r_rval  <= m_hval[r_job.bucket];
            r_rlink <= m_hlink[r_job.bucket];
        end else if (r_state == BS_NODE) begin
            r_rkey  <= m_nkey[w_nidx];
            r_rval  <= m_nval[w_nidx];
            r_rlink <= m_nlink[w_nidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BS_CLEAR) begin
            m_hvalid[r_clr] <= 1'b0;
        end else if (r_state == BS_HEADCHK && r_job.operation == OP_INSERT && !w_hv) begin
            m_hvalid[r_job.bucket] <= 1'b1;
        end
    end

    // Memory writes on insert.
    always_ff @(posedge i_clk) begin
        if (r_state == BS_HEADCHK && r_job.operation == OP_INSERT) begin
            if (!w_hv) begin
                m_hkey[r_job.bucket]  <= r_job.key;
                m_hval[r_job.bucket]  <= r_job.value_in;
                m_hlink[r_job.bucket] <= '0;
            end else if (r_pool < LinkW'(PoolNodes)) begin
                m_hlink[r_job.bucket] <= r_pool + LinkW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BS_HEADCHK && r_job.operation == OP_INSERT && w_hv
                && r_pool < LinkW'(PoolNodes)) begin
            m_nkey[NodeW'(r_pool)]  <= r_job.key;
            m_nval[NodeW'(r_pool)]  <= r_job.value_in;
            m_nlink[NodeW'(r_pool)] <= r_rlink;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BS_IDLE: begin
                if (!i_empty) r_job <= i_job;
                r_steps <= '0;
            end
            BS_HEADCHK: begin
                r_link <= r_rlink;
                r_vout <= '0;
                if (r_job.operation == OP_INSERT) begin
                    r_status <= (w_hv && r_pool >= LinkW'(PoolNodes)) ? ST_FULL : ST_OK;
                end else if (w_hv && r_rkey == r_job.key) begin
                    r_status <= ST_OK;
                    r_vout   <= r_rval;
                end else begin
                    r_status <= ST_NOTFOUND;
                end
            end
            BS_NODECHK: begin
                r_link  <= r_rlink;
                r_steps <= r_steps + LinkW'(1);
                if (r_rkey == r_job.key) begin
                    r_status <= ST_OK;
                    r_vout   <= r_rval;
                end
            end
            BS_HEAD, BS_NODE, BS_DONE, BS_CLEAR: ;
            default: ;
        endcase
    end

    always_comb begin
        o_pop             = (r_state == BS_IDLE) && !i_empty;
        o_idle            = (r_state == BS_IDLE) && !r_strobe;
        o_strobe          = r_strobe;
        o_rsp.status      = r_status;
        o_rsp.value_out   = r_vout;
        o_rsp.entry_total = r_count;
    end

endmodule

FILE: src/chtk_checker.sv
// ----------------------------------------------------------------------------
// chtk_checker: port-level checks of the hash table unit
// Watches results and configuration handshakes on the top level.
// ----------------------------------------------------------------------------
module chtk_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      o_valid,
    input chtk_pkg::t_rsp            o_rsp,
    input logic                      i_cfg_valid,
    input logic                      o_cfg_ready
);
    import chtk_pkg::*;

    // Results are single-cycle strobes.
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe held");

    // A taken request makes the unit busy.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("busy not raised");

    // Status is never the unused code.
    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.status == ST_OK || o_rsp.status == ST_NOTFOUND
                     || o_rsp.status == ST_FULL)) else $error("bad status");

    // The entry count does not decrease between results in consecutive cycles.
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_valid) && o_valid |-> o_rsp.entry_total >= $past(o_rsp.entry_total))
        else $error("count decreased");

    // Configuration is not accepted while a request is in flight.
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |-> (!busy && !o_valid))
        else $error("config accepted while busy");

endmodule

bind chained_hash_table_int_key_unit chtk_checker u_chtk_checker (
    .i_clk, .i_rst_n, .start, .busy, .o_valid, .o_rsp, .i_cfg_valid, .o_cfg_ready
);
